// ===== src/oas_pkg.sv =====
package oas_pkg;

	localparam int CFG_W = 11;
	localparam int MAX_ATOMS_DEF = 1024;
	localparam int MAX_DIRECTIONS = 255;
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [31:0] AZ_STEP = 32'd1327217885;
	localparam logic [27:0] RAD_TO_TURNS = 28'd170891319;
	localparam logic [47:0] INTENSITY_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [7:0] DIRECTION_COUNT_RESET = 8'd30;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic REG_ATOM_COUNT = 1'b0;
	localparam logic REG_DIRECTION_COUNT = 1'b1;

	typedef struct packed {
		logic operation;
		logic [9:0] atom_index;
		logic signed [15:0] atom_x;
		logic signed [15:0] atom_y;
		logic signed [15:0] atom_z;
		logic signed [15:0] scattering_length;
		logic [15:0] q_value;
		logic last_point;
	} in_t;

	typedef struct packed {
		logic [47:0] intensity;
		logic [15:0] q_echo;
		logic last_point_out;
	} out_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DIR_START,
		S_U_DIV,
		S_U_SQUARE,
		S_ROOT,
		S_AZ_ISSUE,
		S_AZ_WAIT,
		S_DIR_MUL,
		S_Q_MUL,
		S_ATOMS,
		S_DRAIN,
		S_SQUARE,
		S_SQ_SUM,
		S_ACCUM,
		S_T_START,
		S_T_DIV
	} state_t;

	function automatic logic signed [31:0] cordic_atan(input int unsigned i);
		logic signed [31:0] r;
		case (i)
			0: r = 32'sh20000000;
			1: r = 32'sh12E4051D;
			2: r = 32'sh09FB385B;
			3: r = 32'sh051111D4;
			4: r = 32'sh028B0D43;
			5: r = 32'sh0145D7E1;
			6: r = 32'sh00A2F61E;
			7: r = 32'sh00517C55;
			8: r = 32'sh0028BE53;
			9: r = 32'sh00145F2E;
			10: r = 32'sh000A2F98;
			11: r = 32'sh000517CC;
			12: r = 32'sh00028BE6;
			13: r = 32'sh000145F3;
			14: r = 32'sh0000A2F9;
			15: r = 32'sh0000517C;
			default: r = 32'sh0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/oas_ram.sv =====
module oas_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/orientation_averaged_scattering_core.sv =====
// Orientation-averaged scattering intensity. A load word (operation 0) writes one atom into
// the atom store when its index is below MAX_ATOMS and gives no result. A compute word
// (operation 1) holds busy while it runs over every direction in turn. Each direction
// passes through the shared divider, the square root, a wait for the azimuth rotation,
// streaming one atom per cycle from the store read port into the 16-stage CORDIC pipeline,
// draining that pipeline and the setup and accumulation steps. The final average takes one
// more pass through the divider. The result appears for exactly one cycle with done high,
// in the cycle in which busy falls; the receiver cannot stall it, so it must be taken in
// that cycle.
module orientation_averaged_scattering_core #(
	parameter int MAX_ATOMS = oas_pkg::MAX_ATOMS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input oas_pkg::in_t cmd,
	output logic done,
	output oas_pkg::out_t result,
	input logic cfg_we,
	input logic cfg_index,
	input logic [oas_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int CW = $clog2(MAX_ATOMS + 1);
	localparam int NS = oas_pkg::CORDIC_STEPS;

	oas_pkg::state_t state_q, state_d;

	logic [10:0] atom_count_q;
	logic [7:0] direction_count_q;

	logic [15:0] q_q;
	logic last_q;
	logic [7:0] g_q;
	logic [CW-1:0] n_q;
	logic [7:0] k_q;
	logic signed [9:0] m_q;
	logic [30:0] u_q;
	logic [63:0] sq_v_q, sq_root_q, sq_bit_q;
	logic signed [31:0] ca_q, sa_q;
	logic signed [31:0] dx_q, dy_q, dz_q;
	logic signed [31:0] qx_q, qy_q, qz_q;
	logic [CW-1:0] j_q;
	logic signed [47:0] cos_sum_q, sin_sum_q;
	logic [63:0] c2_q, s2_q, sqsum_q, total_q;
	logic [63:0] div_num_q;
	logic [7:0] div_rem_q;
	logic [5:0] div_cnt_q;
	logic div_busy_q;
	oas_pkg::out_t result_q;
	logic done_q;

	logic div_start, az_issue, atom_issue, accept, ram_we;

	// Atom pipeline: store read, projection, phase, CORDIC, weighting.
	logic [63:0] ram_rdata;
	logic v_s1;
	logic signed [47:0] px_s2, py_s2, pz_s2;
	logic signed [15:0] b_s2, b_s3, b_s4, b_s5;
	logic v_s2, v_s3, v_s4, v_s5, t_s5;
	logic signed [49:0] dot_s3;
	logic signed [53:0] hi_s4;
	logic [52:0] lo_s4;
	logic [31:0] ph_s5;
	logic signed [31:0] cx_s6 [NS+1];
	logic signed [31:0] cy_s6 [NS+1];
	logic signed [31:0] cz_s6 [NS+1];
	logic [1:0] cq_s6 [NS+1];
	logic signed [15:0] cb_s6 [NS+1];
	logic cv_s6 [NS+1];
	logic ct_s6 [NS+1];
	logic signed [31:0] cx_nx [NS];
	logic signed [31:0] cy_nx [NS];
	logic signed [31:0] cz_nx [NS];
	logic signed [47:0] bc_s7, bs_s7;
	logic v_s7;
	logic pipe_busy;

	logic signed [9:0] m_w;
	logic [7:0] mag_w;
	logic [63:0] u_num;
	logic [8:0] rem_sh;
	logic [8:0] rem_nx;
	logic div_ge;
	logic [63:0] sq_sum_w;
	logic [61:0] usq;
	logic [31:0] az_ph;
	logic [31:0] ph_pre;
	logic [1:0] quad_pre;
	logic [63:0] atom_ph_full;
	logic signed [31:0] c_post, s_post;
	logic signed [63:0] prod_x, prod_y;
	logic signed [48:0] prod_qx, prod_qy, prod_qz;
	logic signed [47:0] c8, s8, c8a, s8a;
	logic [64:0] tot_sum;

	assign busy = (state_q != oas_pkg::S_IDLE);
	assign accept = start && !busy;
	assign ram_we = accept && (cmd.operation == oas_pkg::OP_LOAD) &&
		(32'(cmd.atom_index) < MAX_ATOMS);
	assign done = done_q;
	assign result = result_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			oas_pkg::S_IDLE: begin
				if (accept && (cmd.operation == oas_pkg::OP_COMPUTE)) begin
					state_d = oas_pkg::S_DIR_START;
				end
			end
			oas_pkg::S_DIR_START: state_d = oas_pkg::S_U_DIV;
			oas_pkg::S_U_DIV: begin
				if (!div_busy_q) begin
					state_d = oas_pkg::S_U_SQUARE;
				end
			end
			oas_pkg::S_U_SQUARE: state_d = oas_pkg::S_ROOT;
			oas_pkg::S_ROOT: begin
				if (sq_bit_q == 64'd0) begin
					state_d = oas_pkg::S_AZ_ISSUE;
				end
			end
			oas_pkg::S_AZ_ISSUE: state_d = oas_pkg::S_AZ_WAIT;
			oas_pkg::S_AZ_WAIT: begin
				if (cv_s6[NS] && ct_s6[NS]) begin
					state_d = oas_pkg::S_DIR_MUL;
				end
			end
			oas_pkg::S_DIR_MUL: state_d = oas_pkg::S_Q_MUL;
			oas_pkg::S_Q_MUL: state_d = oas_pkg::S_ATOMS;
			oas_pkg::S_ATOMS: begin
				if (j_q == n_q) begin
					state_d = oas_pkg::S_DRAIN;
				end
			end
			oas_pkg::S_DRAIN: begin
				if (!pipe_busy) begin
					state_d = oas_pkg::S_SQUARE;
				end
			end
			oas_pkg::S_SQUARE: state_d = oas_pkg::S_SQ_SUM;
			oas_pkg::S_SQ_SUM: state_d = oas_pkg::S_ACCUM;
			oas_pkg::S_ACCUM: begin
				if ({1'b0, k_q} + 9'd1 == {1'b0, g_q}) begin
					state_d = oas_pkg::S_T_START;
				end else begin
					state_d = oas_pkg::S_DIR_START;
				end
			end
			oas_pkg::S_T_START: state_d = oas_pkg::S_T_DIV;
			oas_pkg::S_T_DIV: begin
				if (!div_busy_q) begin
					state_d = oas_pkg::S_IDLE;
				end
			end
			default: state_d = oas_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		div_start = 1'b0;
		az_issue = 1'b0;
		atom_issue = 1'b0;
		case (state_q)
			oas_pkg::S_DIR_START: div_start = 1'b1;
			oas_pkg::S_T_START: div_start = 1'b1;
			oas_pkg::S_AZ_ISSUE: az_issue = 1'b1;
			oas_pkg::S_ATOMS: atom_issue = (j_q != n_q);
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oas_pkg::S_IDLE;
			atom_count_q <= 11'd0;
			direction_count_q <= oas_pkg::DIRECTION_COUNT_RESET;
			div_busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == oas_pkg::S_T_DIV) && !div_busy_q;
			if (cfg_we) begin
				case (cfg_index)
					oas_pkg::REG_ATOM_COUNT: atom_count_q <= cfg_data;
					oas_pkg::REG_DIRECTION_COUNT: direction_count_q <= cfg_data[7:0];
					default: atom_count_q <= atom_count_q;
				endcase
			end
			if (div_start) begin
				div_busy_q <= 1'b1;
			end else if (div_busy_q && (div_cnt_q == 6'd63)) begin
				div_busy_q <= 1'b0;
			end
		end
	end

	assign m_w = $signed({1'b0, k_q, 1'b0}) - $signed({2'b00, g_q}) + 10'sd1;
	assign mag_w = m_w[9] ? 8'(-m_w) : 8'(m_w);
	assign u_num = 64'({mag_w, 30'd0}) + 64'(g_q >> 1);

	assign rem_sh = {div_rem_q, div_num_q[63]};
	assign div_ge = (rem_sh >= {1'b0, g_q});
	assign rem_nx = div_ge ? (rem_sh - {1'b0, g_q}) : rem_sh;

	assign usq = u_q * u_q;
	assign sq_sum_w = sq_root_q + sq_bit_q;

	assign prod_x = $signed({1'b0, sq_root_q[30:0]}) * ca_q;
	assign prod_y = $signed({1'b0, sq_root_q[30:0]}) * sa_q;
	assign prod_qx = $signed({1'b0, q_q}) * dx_q;
	assign prod_qy = $signed({1'b0, q_q}) * dy_q;
	assign prod_qz = $signed({1'b0, q_q}) * dz_q;

	assign c8 = (cos_sum_q + 48'sd128) >>> 8;
	assign s8 = (sin_sum_q + 48'sd128) >>> 8;
	assign c8a = c8[47] ? -c8 : c8;
	assign s8a = s8[47] ? -s8 : s8;
	assign tot_sum = {1'b0, total_q} + {1'b0, sqsum_q};

	always_ff @(posedge clk) begin
		if (accept && (cmd.operation == oas_pkg::OP_COMPUTE)) begin
			q_q <= cmd.q_value;
			last_q <= cmd.last_point;
			if (direction_count_q == 8'd0) begin
				g_q <= 8'd1;
			end else if (32'(direction_count_q) > oas_pkg::MAX_DIRECTIONS) begin
				g_q <= 8'(oas_pkg::MAX_DIRECTIONS);
			end else begin
				g_q <= direction_count_q;
			end
			if (32'(atom_count_q) > MAX_ATOMS) begin
				n_q <= CW'(MAX_ATOMS);
			end else begin
				n_q <= CW'(atom_count_q);
			end
			k_q <= 8'd0;
			total_q <= 64'd0;
		end

		if (div_start) begin
			div_num_q <= (state_q == oas_pkg::S_DIR_START) ? u_num : total_q;
			div_rem_q <= 8'd0;
			div_cnt_q <= 6'd0;
		end else if (div_busy_q) begin
			div_num_q <= {div_num_q[62:0], div_ge};
			div_rem_q <= rem_nx[7:0];
			div_cnt_q <= div_cnt_q + 6'd1;
		end

		case (state_q)
			oas_pkg::S_DIR_START: begin
				m_q <= m_w;
				cos_sum_q <= 48'sd0;
				sin_sum_q <= 48'sd0;
			end
			oas_pkg::S_U_DIV: begin
				u_q <= div_num_q[30:0];
			end
			oas_pkg::S_U_SQUARE: begin
				sq_v_q <= 64'h1000_0000_0000_0000 - 64'(usq);
				sq_root_q <= 64'd0;
				sq_bit_q <= 64'h4000_0000_0000_0000;
			end
			oas_pkg::S_ROOT: begin
				if (sq_bit_q != 64'd0) begin
					if (sq_v_q >= sq_sum_w) begin
						sq_v_q <= sq_v_q - sq_sum_w;
						sq_root_q <= (sq_root_q >> 1) + sq_bit_q;
					end else begin
						sq_root_q <= sq_root_q >> 1;
					end
					sq_bit_q <= sq_bit_q >> 2;
				end
			end
			oas_pkg::S_AZ_WAIT: begin
				ca_q <= c_post;
				sa_q <= s_post;
			end
			oas_pkg::S_DIR_MUL: begin
				dx_q <= prod_x[61:30];
				dy_q <= prod_y[61:30];
				dz_q <= m_q[9] ? -$signed({1'b0, u_q}) : $signed({1'b0, u_q});
			end
			oas_pkg::S_Q_MUL: begin
				qx_q <= prod_qx[47:16];
				qy_q <= prod_qy[47:16];
				qz_q <= prod_qz[47:16];
				j_q <= '0;
			end
			oas_pkg::S_ATOMS: begin
				if (atom_issue) begin
					j_q <= j_q + 1'b1;
				end
			end
			oas_pkg::S_SQUARE: begin
				c2_q <= c8a[31:0] * c8a[31:0];
				s2_q <= s8a[31:0] * s8a[31:0];
			end
			oas_pkg::S_SQ_SUM: begin
				sqsum_q <= c2_q + s2_q;
			end
			oas_pkg::S_ACCUM: begin
				total_q <= tot_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : tot_sum[63:0];
				k_q <= k_q + 8'd1;
			end
			oas_pkg::S_T_DIV: begin
				if (!div_busy_q) begin
					result_q.intensity <= (|div_num_q[63:48]) ? oas_pkg::INTENSITY_MAX :
						div_num_q[47:0];
					result_q.q_echo <= q_q;
					result_q.last_point_out <= last_q;
				end
			end
			default: begin
			end
		endcase

		if (v_s7) begin
			cos_sum_q <= cos_sum_q + (bc_s7 >>> 22);
			sin_sum_q <= sin_sum_q + (bs_s7 >>> 22);
		end
	end

	oas_ram #(
		.WIDTH(64),
		.DEPTH(MAX_ATOMS)
	) u_atom_store (
		.clk(clk),
		.we(ram_we),
		.waddr(AW'(cmd.atom_index)),
		.wdata({cmd.scattering_length, cmd.atom_z, cmd.atom_y, cmd.atom_x}),
		.re(atom_issue),
		.raddr(j_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign az_ph = {{22{m_q[9]}}, m_q} * oas_pkg::AZ_STEP;
	assign atom_ph_full = {{10{hi_s4[53]}}, hi_s4} * 64'd33554432 + {11'd0, lo_s4};
	assign quad_pre = 2'((ph_s5 + 32'h2000_0000) >> 30);
	assign ph_pre = ph_s5 - {quad_pre, 30'd0};

	always_comb begin
		for (int i = 0; i < NS; i++) begin
			if (!cz_s6[i][31]) begin
				cx_nx[i] = cx_s6[i] - (cy_s6[i] >>> i);
				cy_nx[i] = cy_s6[i] + (cx_s6[i] >>> i);
				cz_nx[i] = cz_s6[i] - oas_pkg::cordic_atan(i);
			end else begin
				cx_nx[i] = cx_s6[i] + (cy_s6[i] >>> i);
				cy_nx[i] = cy_s6[i] - (cx_s6[i] >>> i);
				cz_nx[i] = cz_s6[i] + oas_pkg::cordic_atan(i);
			end
		end
	end

	always_comb begin
		case (cq_s6[NS])
			2'd0: begin
				c_post = cx_s6[NS];
				s_post = cy_s6[NS];
			end
			2'd1: begin
				c_post = -cy_s6[NS];
				s_post = cx_s6[NS];
			end
			2'd2: begin
				c_post = -cx_s6[NS];
				s_post = -cy_s6[NS];
			end
			default: begin
				c_post = cy_s6[NS];
				s_post = -cx_s6[NS];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		px_s2 <= qx_q * $signed(ram_rdata[15:0]);
		py_s2 <= qy_q * $signed(ram_rdata[31:16]);
		pz_s2 <= qz_q * $signed(ram_rdata[47:32]);
		b_s2 <= $signed(ram_rdata[63:48]);
		dot_s3 <= 50'(px_s2) + 50'(py_s2) + 50'(pz_s2);
		b_s3 <= b_s2;
		hi_s4 <= $signed(dot_s3[49:25]) * $signed({1'b0, oas_pkg::RAD_TO_TURNS});
		lo_s4 <= dot_s3[24:0] * oas_pkg::RAD_TO_TURNS;
		b_s4 <= b_s3;
		ph_s5 <= az_issue ? az_ph : atom_ph_full[63:32];
		b_s5 <= b_s4;
		cx_s6[0] <= oas_pkg::CORDIC_GAIN;
		cy_s6[0] <= 32'sd0;
		cz_s6[0] <= $signed(ph_pre);
		cq_s6[0] <= quad_pre;
		cb_s6[0] <= b_s5;
		for (int i = 0; i < NS; i++) begin
			cx_s6[i+1] <= cx_nx[i];
			cy_s6[i+1] <= cy_nx[i];
			cz_s6[i+1] <= cz_nx[i];
			cq_s6[i+1] <= cq_s6[i];
			cb_s6[i+1] <= cb_s6[i];
		end
		bc_s7 <= cb_s6[NS] * c_post;
		bs_s7 <= cb_s6[NS] * s_post;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			t_s5 <= 1'b0;
			for (int i = 0; i <= NS; i++) begin
				cv_s6[i] <= 1'b0;
				ct_s6[i] <= 1'b0;
			end
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= atom_issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 || az_issue;
			t_s5 <= az_issue;
			cv_s6[0] <= v_s5;
			ct_s6[0] <= t_s5;
			for (int i = 0; i < NS; i++) begin
				cv_s6[i+1] <= cv_s6[i];
				ct_s6[i+1] <= ct_s6[i];
			end
			v_s7 <= cv_s6[NS] && !ct_s6[NS];
		end
	end

	always_comb begin
		pipe_busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s7;
		for (int i = 0; i <= NS; i++) begin
			pipe_busy = pipe_busy | cv_s6[i];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == oas_pkg::S_IDLE))
		else $error("Result strobe while a compute word is still running.");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy_q)
		else $error("Divider restarted before finishing.");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s7 |-> (state_q == oas_pkg::S_ATOMS || state_q == oas_pkg::S_DRAIN))
		else $error("Atom term arrived outside the atom sweep.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cv_s6[NS] && ct_s6[NS]) |-> (state_q == oas_pkg::S_AZ_WAIT))
		else $error("Azimuth rotation finished outside its wait state.");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !atom_issue)
		else $error("Atom store written during an atom sweep.");

endmodule
